// ===== rtl/json_string_unescaper_macros.svh =====
// assertion helpers used by the checker file
`ifndef JSON_STRING_UNESCAPER_MACROS_SVH
`define JSON_STRING_UNESCAPER_MACROS_SVH

// same-cycle implication, sampled on clk_i, quiet while rst_ni is low
`define JSU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("jsu check failed");

// next-cycle implication, sampled on clk_i, quiet while rst_ni is low
`define JSU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("jsu check failed");

`endif

// ===== rtl/jsu_pkg.sv =====
package jsu_pkg;

  localparam int unsigned MaxResults = 4;
  localparam int unsigned CntW       = $clog2(MaxResults + 1);
  localparam int unsigned IdxW       = $clog2(MaxResults);

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    ERR_NONE        = 4'd0,
    ERR_NO_QUOTE    = 4'd1,
    ERR_CTRL_CHAR   = 4'd2,
    ERR_INC_ESCAPE  = 4'd3,
    ERR_BAD_ESCAPE  = 4'd4,
    ERR_SHORT_UNI   = 4'd5,
    ERR_BAD_HEX     = 4'd6,
    ERR_LONE_HIGH   = 4'd7,
    ERR_BAD_LOW     = 4'd8,
    ERR_LONE_LOW    = 4'd9,
    ERR_UNTERM      = 4'd10
  } err_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       input_end;
  } in_item_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] out_byte;
    err_e       error_code;
    logic       last;
  } out_item_t;

  // results caused by one request, entry 0 leaves first
  typedef struct packed {
    out_item_t [MaxResults-1:0] res;
    logic [CntW-1:0]            cnt;
  } grp_t;

endpackage

// ===== rtl/jsu_decode.sv =====
module jsu_decode import jsu_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     take_i,
  input  in_item_t item_i,
  output grp_t     grp_o
);

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_BODY    = 3'd1,
    PH_ESC     = 3'd2,
    PH_HEX     = 3'd3,
    PH_PAIR_BS = 3'd4,
    PH_PAIR_U  = 3'd5,
    PH_LOW     = 3'd6
  } phase_e;

  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5c;
  localparam logic [7:0] ChSlash  = 8'h2f;
  localparam logic [7:0] ChB      = 8'h62;
  localparam logic [7:0] ChF      = 8'h66;
  localparam logic [7:0] ChN      = 8'h6e;
  localparam logic [7:0] ChR      = 8'h72;
  localparam logic [7:0] ChT      = 8'h74;
  localparam logic [7:0] ChU      = 8'h75;
  localparam logic [7:0] ChSpace  = 8'h20;

  localparam logic [5:0]  SurrHighTag = 6'b110110;
  localparam logic [5:0]  SurrLowTag  = 6'b110111;
  localparam logic [20:0] SuppBase    = 21'h10000;

  phase_e      phase_q, phase_d;
  logic [11:0] acc_q, acc_d;
  logic [1:0]  dig_q, dig_d;
  logic [9:0]  high_q, high_d;

  logic [7:0]  c;
  logic        e;
  logic [4:0]  hex;
  logic [8:0]  esc;
  logic [15:0] unit;
  logic [20:0] pair_cp;
  grp_t        grp;

  function automatic logic [4:0] hex_value(input logic [7:0] ch);
    logic [4:0] r;
    r = 5'd0;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      r = {1'b1, 4'(ch - 8'h30)};
    end else if (ch >= 8'h61 && ch <= 8'h66) begin
      r = {1'b1, 4'(ch - 8'h57)};
    end else if (ch >= 8'h41 && ch <= 8'h46) begin
      r = {1'b1, 4'(ch - 8'h37)};
    end
    return r;
  endfunction

  function automatic logic [8:0] esc_map(input logic [7:0] ch);
    logic [8:0] r;
    case (ch)
      ChQuote:  r = {1'b1, ChQuote};
      ChBslash: r = {1'b1, ChBslash};
      ChSlash:  r = {1'b1, ChSlash};
      ChB:      r = {1'b1, 8'h08};
      ChF:      r = {1'b1, 8'h0c};
      ChN:      r = {1'b1, 8'h0a};
      ChR:      r = {1'b1, 8'h0d};
      ChT:      r = {1'b1, 8'h09};
      default:  r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic out_item_t data_item(input logic [7:0] b);
    out_item_t r;
    r.kind       = KIND_DATA;
    r.out_byte   = b;
    r.error_code = ERR_NONE;
    r.last       = 1'b0;
    return r;
  endfunction

  function automatic grp_t one_item(input kind_e k, input logic [7:0] b, input err_e er);
    grp_t r;
    r                   = '0;
    r.res[0].kind       = k;
    r.res[0].out_byte   = b;
    r.res[0].error_code = er;
    r.cnt               = CntW'(1);
    return r;
  endfunction

  // utf-8 bytes of one code point, none for code point zero
  function automatic grp_t utf8_encode(input logic [20:0] cp);
    grp_t r;
    r = '0;
    if (cp == 21'd0) begin
      r.cnt = '0;
    end else if (cp <= 21'h7f) begin
      r.res[0] = data_item(cp[7:0]);
      r.cnt    = CntW'(1);
    end else if (cp <= 21'h7ff) begin
      r.res[0] = data_item({3'b110, cp[10:6]});
      r.res[1] = data_item({2'b10, cp[5:0]});
      r.cnt    = CntW'(2);
    end else if (cp <= 21'hffff) begin
      r.res[0] = data_item({4'b1110, cp[15:12]});
      r.res[1] = data_item({2'b10, cp[11:6]});
      r.res[2] = data_item({2'b10, cp[5:0]});
      r.cnt    = CntW'(3);
    end else begin
      r.res[0] = data_item({5'b11110, cp[20:18]});
      r.res[1] = data_item({2'b10, cp[17:12]});
      r.res[2] = data_item({2'b10, cp[11:6]});
      r.res[3] = data_item({2'b10, cp[5:0]});
      r.cnt    = CntW'(4);
    end
    return r;
  endfunction

  assign c       = item_i.in_byte;
  assign e       = item_i.input_end;
  assign hex     = hex_value(c);
  assign esc     = esc_map(c);
  assign unit    = {acc_q, hex[3:0]};
  assign pair_cp = SuppBase + {1'b0, high_q, unit[9:0]};

  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    dig_d   = dig_q;
    high_d  = high_q;
    grp     = '0;

    case (phase_q)
      PH_IDLE: begin
        if (!e && c == ChQuote) begin
          phase_d = PH_BODY;
        end else begin
          grp = one_item(KIND_ERROR, 8'd0, ERR_NO_QUOTE);
        end
      end
      PH_BODY: begin
        if (e) begin
          grp = one_item(KIND_ERROR, 8'd0, ERR_UNTERM);
        end else if (c == ChQuote) begin
          phase_d = PH_IDLE;
          grp     = one_item(KIND_DONE, 8'd0, ERR_NONE);
        end else if (c < ChSpace) begin
          grp = one_item(KIND_ERROR, 8'd0, ERR_CTRL_CHAR);
        end else if (c == ChBslash) begin
          phase_d = PH_ESC;
        end else begin
          grp = one_item(KIND_DATA, c, ERR_NONE);
        end
      end
      PH_ESC: begin
        if (e) begin
          grp = one_item(KIND_ERROR, 8'd0, ERR_INC_ESCAPE);
        end else if (c == ChU) begin
          phase_d = PH_HEX;
          acc_d   = '0;
          dig_d   = '0;
        end else if (esc[8]) begin
          phase_d = PH_BODY;
          grp     = one_item(KIND_DATA, esc[7:0], ERR_NONE);
        end else begin
          grp = one_item(KIND_ERROR, 8'd0, ERR_BAD_ESCAPE);
        end
      end
      PH_HEX, PH_LOW: begin
        if (e) begin
          grp = one_item(KIND_ERROR, 8'd0, ERR_SHORT_UNI);
        end else if (!hex[4]) begin
          grp = one_item(KIND_ERROR, 8'd0, ERR_BAD_HEX);
        end else if (dig_q != 2'd3) begin
          acc_d = unit[11:0];
          dig_d = dig_q + 2'd1;
        end else begin
          acc_d = '0;
          dig_d = '0;
          if (phase_q == PH_HEX) begin
            if (unit[15:10] == SurrHighTag) begin
              high_d  = unit[9:0];
              phase_d = PH_PAIR_BS;
            end else if (unit[15:10] == SurrLowTag) begin
              grp = one_item(KIND_ERROR, 8'd0, ERR_LONE_LOW);
            end else begin
              phase_d = PH_BODY;
              grp     = utf8_encode({5'd0, unit});
            end
          end else if (unit[15:10] != SurrLowTag) begin
            grp = one_item(KIND_ERROR, 8'd0, ERR_BAD_LOW);
          end else begin
            high_d  = '0;
            phase_d = PH_BODY;
            grp     = utf8_encode(pair_cp);
          end
        end
      end
      PH_PAIR_BS: begin
        if (e || c != ChBslash) begin
          grp = one_item(KIND_ERROR, 8'd0, ERR_LONE_HIGH);
        end else begin
          phase_d = PH_PAIR_U;
        end
      end
      PH_PAIR_U: begin
        if (e || c != ChU) begin
          grp = one_item(KIND_ERROR, 8'd0, ERR_LONE_HIGH);
        end else begin
          phase_d = PH_LOW;
          acc_d   = '0;
          dig_d   = '0;
        end
      end
      default: begin
        grp = one_item(KIND_ERROR, 8'd0, ERR_NO_QUOTE);
      end
    endcase

    // any fault drops back to idle with the unit state cleared
    if (grp.cnt != '0 && grp.res[0].kind == KIND_ERROR) begin
      phase_d = PH_IDLE;
      acc_d   = '0;
      dig_d   = '0;
      high_d  = '0;
    end

    for (int i = 0; i < MaxResults; i++) begin
      grp.res[i].last = (CntW'(i) + CntW'(1) == grp.cnt);
    end
  end

  assign grp_o = grp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      acc_q   <= '0;
      dig_q   <= '0;
      high_q  <= '0;
    end else if (take_i) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      dig_q   <= dig_d;
      high_q  <= high_d;
    end
  end

endmodule

// ===== rtl/json_string_unescaper.sv =====
// json string unescaper: takes the text of one quoted json string one byte per
// request, with an end mark, and returns the decoded utf-8 bytes followed by a
// done result, or a single error result after which it waits for a new opening
// quote. each request gives zero to four results; the last result of a request
// carries last. requests are taken at one per cycle while the result buffer is
// free; a request that yields k results holds the four-entry result buffer
// until all k have left, and the next request's results wait behind it, while
// the two-entry input skid keeps in_ready_o a registered signal.
module json_string_unescaper import jsu_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  // input skid: head feeds the decoder, skid catches a request while head stalls
  in_item_t head_q, skid_q;
  logic     head_v_q, skid_v_q;

  // result buffer: the group of one request, read out entry by entry
  out_item_t [MaxResults-1:0] res_q;
  logic [CntW-1:0]            cnt_q;
  logic [IdxW-1:0]            idx_q;

  grp_t grp;
  logic push, take, out_fire, drain_last, buf_free;

  assign in_ready_o  = !skid_v_q;
  assign push        = in_valid_i && in_ready_o;

  assign out_valid_o = cnt_q != '0;
  assign out_data_o  = res_q[idx_q];
  assign out_fire    = out_valid_o && out_ready_i;
  assign drain_last  = out_fire && ({1'b0, idx_q} + CntW'(1) == cnt_q);

  // buffer can take a new group once empty or when its last entry leaves now
  assign buf_free    = (cnt_q == '0) || drain_last;
  assign take        = head_v_q && buf_free;

  jsu_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .item_i (head_q),
    .grp_o  (grp)
  );

  // skid control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (take) begin
      if (skid_v_q) begin
        skid_v_q <= 1'b0;
      end else begin
        head_v_q <= push;
      end
    end else if (push) begin
      if (head_v_q) begin
        skid_v_q <= 1'b1;
      end else begin
        head_v_q <= 1'b1;
      end
    end
  end

  // skid payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      if (skid_v_q) begin
        head_q <= skid_q;
      end else if (push) begin
        head_q <= in_data_i;
      end
    end else if (push) begin
      if (head_v_q) begin
        skid_q <= in_data_i;
      end else begin
        head_q <= in_data_i;
      end
    end
  end

  // result buffer control, a new group wins over draining the old one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else if (take && grp.cnt != '0) begin
      cnt_q <= grp.cnt;
      idx_q <= '0;
    end else if (drain_last) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else if (out_fire) begin
      idx_q <= idx_q + IdxW'(1);
    end
  end

  // result buffer payload
  always_ff @(posedge clk_i) begin
    if (take && grp.cnt != '0) begin
      res_q <= grp.res;
    end
  end

endmodule

// ===== rtl/jsu_checker.sv =====
`include "json_string_unescaper_macros.svh"

module jsu_checker import jsu_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_data_o
);

  logic fields_clean;

  // data bytes carry no error code, other results carry no byte
  assign fields_clean = (out_data_o.kind == KIND_DATA) ? (out_data_o.error_code == ERR_NONE)
                                                       : (out_data_o.out_byte == 8'd0);

  // a stalled result keeps its contents
  `JSU_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))

  // done and error results are always the final result of their request
  `JSU_ASSERT_NOW(a_ctrl_last, out_valid_o && out_data_o.kind != KIND_DATA, out_data_o.last)

  `JSU_ASSERT_NOW(a_fields_clean, out_valid_o, fields_clean)

  // input only backs up while results are waiting
  `JSU_ASSERT_NOW(a_stall_cause, !in_ready_o, out_valid_o)

endmodule

bind json_string_unescaper jsu_checker u_jsu_checker (.*);

// ===== tb/testbench.sv =====
module testbench;
  import jsu_pkg::*;

  // character codes that steer the string scanner
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  // utf-16 surrogate bounds
  localparam logic [15:0] SURR_HIGH_MIN = 16'hd800;
  localparam logic [15:0] SURR_HIGH_MAX = 16'hdbff;
  localparam logic [15:0] SURR_LOW_MIN  = 16'hdc00;
  localparam logic [15:0] SURR_LOW_MAX  = 16'hdfff;

  // run length: at least 400 requests in all, directed opening included
  localparam int unsigned TOTAL_REQS  = 400;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT  = 300000;

  // decoder state mirror and the queue of results still owed by the block
  class unescape_scoreboard;
    typedef enum logic [2:0] {
      SCAN_IDLE,
      SCAN_BODY,
      SCAN_ESCAPE,
      SCAN_HEX,
      SCAN_PAIR_BSLASH,
      SCAN_PAIR_U,
      SCAN_LOW_HEX
    } scan_e;

    scan_e       scan;
    logic [15:0] unit_acc;
    logic [1:0]  digit_cnt;
    logic [9:0]  high_half;
    out_item_t   owed_q[$];
    out_item_t   burst_q[$];
    int unsigned mismatches;
    int unsigned requests;
    int unsigned checked;
    int unsigned strings_closed;
    int unsigned faults;

    function new();
      scan           = SCAN_IDLE;
      unit_acc       = '0;
      digit_cnt      = '0;
      high_half      = '0;
      mismatches     = 0;
      requests       = 0;
      checked        = 0;
      strings_closed = 0;
      faults         = 0;
    endfunction

    // -1 when the byte is not a hex digit
    static function int digit_of(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - "0");
      if (c >= "a" && c <= "f") return int'(c - "a") + 10;
      if (c >= "A" && c <= "F") return int'(c - "A") + 10;
      return -1;
    endfunction

    // bit 8 set means not a short escape letter
    static function logic [8:0] short_escape(logic [7:0] c);
      case (c)
        CH_QUOTE:  return {1'b0, CH_QUOTE};
        CH_BSLASH: return {1'b0, CH_BSLASH};
        "/":       return 9'h02f;
        "b":       return 9'h008;
        "f":       return 9'h00c;
        "n":       return 9'h00a;
        "r":       return 9'h00d;
        "t":       return 9'h009;
        default:   return 9'h100;
      endcase
    endfunction

    function void emit(kind_e kind, logic [7:0] data, err_e code);
      out_item_t r;
      r.kind       = kind;
      r.out_byte   = data;
      r.error_code = code;
      r.last       = 1'b0;
      burst_q.push_back(r);
    endfunction

    function void fault(err_e code);
      scan      = SCAN_IDLE;
      unit_acc  = '0;
      digit_cnt = '0;
      high_half = '0;
      emit(KIND_ERROR, 8'h00, code);
    endfunction

    // code point to one to four utf-8 bytes, nul gives nothing
    function void emit_utf8(logic [20:0] cp);
      if (cp == '0) return;
      if (cp <= 21'h7f) begin
        emit(KIND_DATA, cp[7:0], ERR_NONE);
      end else if (cp <= 21'h7ff) begin
        emit(KIND_DATA, {3'b110, cp[10:6]}, ERR_NONE);
        emit(KIND_DATA, {2'b10, cp[5:0]}, ERR_NONE);
      end else if (cp <= 21'hffff) begin
        emit(KIND_DATA, {4'b1110, cp[15:12]}, ERR_NONE);
        emit(KIND_DATA, {2'b10, cp[11:6]}, ERR_NONE);
        emit(KIND_DATA, {2'b10, cp[5:0]}, ERR_NONE);
      end else begin
        emit(KIND_DATA, {5'b11110, cp[20:18]}, ERR_NONE);
        emit(KIND_DATA, {2'b10, cp[17:12]}, ERR_NONE);
        emit(KIND_DATA, {2'b10, cp[11:6]}, ERR_NONE);
        emit(KIND_DATA, {2'b10, cp[5:0]}, ERR_NONE);
      end
    endfunction

    function void note_request(in_item_t req);
      logic [7:0]  c;
      logic        fin;
      int          d;
      logic [8:0]  mapped;
      logic [15:0] unit;
      out_item_t   r;
      c   = req.in_byte;
      fin = req.input_end;
      requests++;
      burst_q.delete();
      case (scan)
        SCAN_IDLE: begin
          if (!fin && c == CH_QUOTE) scan = SCAN_BODY;
          else fault(ERR_NO_QUOTE);
        end
        SCAN_BODY: begin
          if (fin) fault(ERR_UNTERM);
          else if (c == CH_QUOTE) begin
            scan = SCAN_IDLE;
            emit(KIND_DONE, 8'h00, ERR_NONE);
          end else if (c < CH_SPACE) fault(ERR_CTRL_CHAR);
          else if (c == CH_BSLASH) scan = SCAN_ESCAPE;
          else emit(KIND_DATA, c, ERR_NONE);
        end
        SCAN_ESCAPE: begin
          mapped = short_escape(c);
          if (fin) fault(ERR_INC_ESCAPE);
          else if (c == CH_U) begin
            scan      = SCAN_HEX;
            unit_acc  = '0;
            digit_cnt = '0;
          end else if (!mapped[8]) begin
            scan = SCAN_BODY;
            emit(KIND_DATA, mapped[7:0], ERR_NONE);
          end else fault(ERR_BAD_ESCAPE);
        end
        SCAN_HEX, SCAN_LOW_HEX: begin
          d = digit_of(c);
          if (fin) fault(ERR_SHORT_UNI);
          else if (d < 0) fault(ERR_BAD_HEX);
          else begin
            unit = {unit_acc[11:0], d[3:0]};
            if (digit_cnt != 2'd3) begin
              unit_acc  = unit;
              digit_cnt = digit_cnt + 2'd1;
            end else begin
              unit_acc  = '0;
              digit_cnt = '0;
              if (scan == SCAN_HEX) begin
                if (unit >= SURR_HIGH_MIN && unit <= SURR_HIGH_MAX) begin
                  // bounds are 1k aligned so the offset is just the low ten bits
                  high_half = unit[9:0];
                  scan      = SCAN_PAIR_BSLASH;
                end else if (unit >= SURR_LOW_MIN && unit <= SURR_LOW_MAX) begin
                  fault(ERR_LONE_LOW);
                end else begin
                  scan = SCAN_BODY;
                  emit_utf8({5'd0, unit});
                end
              end else if (unit < SURR_LOW_MIN || unit > SURR_LOW_MAX) begin
                fault(ERR_BAD_LOW);
              end else begin
                scan = SCAN_BODY;
                emit_utf8(21'h10000 + {1'b0, high_half, unit[9:0]});
                high_half = '0;
              end
            end
          end
        end
        SCAN_PAIR_BSLASH: begin
          if (fin || c != CH_BSLASH) fault(ERR_LONE_HIGH);
          else scan = SCAN_PAIR_U;
        end
        SCAN_PAIR_U: begin
          if (fin || c != CH_U) fault(ERR_LONE_HIGH);
          else begin
            scan      = SCAN_LOW_HEX;
            unit_acc  = '0;
            digit_cnt = '0;
          end
        end
        default: fault(ERR_NO_QUOTE);
      endcase
      foreach (burst_q[i]) begin
        r      = burst_q[i];
        r.last = (i == burst_q.size() - 1);
        owed_q.push_back(r);
      end
    endfunction

    function void field_mismatch(string field, logic [7:0] want_v, logic [7:0] got_v);
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want_v, got_v);
      mismatches++;
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      checked++;
      if (owed_q.size() == 0) begin
        $display("%0t: stray result, expected none, got kind %0d byte %0h code %0d last %0b",
                 $time, got.kind, got.out_byte, got.error_code, got.last);
        mismatches++;
        return;
      end
      want = owed_q.pop_front();
      if (want.kind == KIND_DONE) strings_closed++;
      if (want.kind == KIND_ERROR) faults++;
      if (got.kind !== want.kind) field_mismatch("kind", want.kind, got.kind);
      if (got.out_byte !== want.out_byte) field_mismatch("out_byte", want.out_byte, got.out_byte);
      if (got.error_code !== want.error_code)
        field_mismatch("error_code", want.error_code, got.error_code);
      if (got.last !== want.last) field_mismatch("last", want.last, got.last);
    endfunction
  endclass

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_item_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_data_o;

  unescape_scoreboard sb = new();

  int unsigned src_idle  = 30;
  int unsigned sink_idle = 76;
  int unsigned reqs_sent = 0;
  int unsigned cycle_cnt = 0;
  in_item_t    text_q[$];

  json_string_unescaper uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog, far beyond the slowest legal run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result side: check what is taken, then pick next cycle's ready at random
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) sb.check_result(out_data_o);
    out_ready_i <= ($urandom_range(99) >= sink_idle);
  end

  // ---- building request text ----

  function automatic void add_byte(logic [7:0] b);
    in_item_t r;
    r.in_byte   = b;
    r.input_end = 1'b0;
    text_q.push_back(r);
  endfunction

  // end mark, with a random byte riding along that the block must ignore
  function automatic void add_end();
    in_item_t r;
    r.in_byte   = 8'($urandom);
    r.input_end = 1'b1;
    text_q.push_back(r);
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  // hex digit with letters in either case
  function automatic logic [7:0] hex_char(logic [3:0] d);
    if (d < 4'd10) return 8'("0" + d);
    return 8'(($urandom_range(1) ? "a" : "A") + d - 10);
  endfunction

  function automatic void add_unit(logic [15:0] u);
    add_byte(CH_BSLASH);
    add_byte(CH_U);
    for (int i = 3; i >= 0; i--) add_byte(hex_char(u[4*i +: 4]));
  endfunction

  // any printable or high byte that does not steer the scanner
  function automatic logic [7:0] pick_plain();
    logic [7:0] c;
    do c = 8'($urandom_range(8'h20, 8'hff)); while (c == CH_QUOTE || c == CH_BSLASH);
    return c;
  endfunction

  function automatic logic [7:0] pick_short_escape();
    case ($urandom_range(7))
      0: return CH_QUOTE;
      1: return CH_BSLASH;
      2: return "/";
      3: return "b";
      4: return "f";
      5: return "n";
      6: return "r";
      default: return "t";
    endcase
  endfunction

  function automatic logic [7:0] pick_bad_escape();
    logic [7:0] c;
    logic [8:0] m;
    do begin
      c = 8'($urandom);
      m = unescape_scoreboard::short_escape(c);
    end while (!m[8] || c == CH_U);
    return c;
  endfunction

  function automatic logic [7:0] pick_non_hex();
    logic [7:0] c;
    do c = 8'($urandom); while (unescape_scoreboard::digit_of(c) >= 0);
    return c;
  endfunction

  // basic plane unit away from the surrogates, edges of each utf-8 length included
  function automatic logic [15:0] pick_bmp();
    logic [15:0] u;
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(8))
          0: u = 16'h0000;
          1: u = 16'h0001;
          2: u = 16'h007f;
          3: u = 16'h0080;
          4: u = 16'h07ff;
          5: u = 16'h0800;
          6: u = 16'hd7ff;
          7: u = 16'he000;
          default: u = 16'hffff;
        endcase
      end
      1, 2, 3: u = 16'($urandom_range(16'h0001, 16'h007f));
      4, 5, 6: u = 16'($urandom_range(16'h0080, 16'h07ff));
      default: begin
        do u = 16'($urandom_range(16'h0800, 16'hffff));
        while (u >= SURR_HIGH_MIN && u <= SURR_LOW_MAX);
      end
    endcase
    return u;
  endfunction

  function automatic logic [15:0] pick_high();
    case ($urandom_range(3))
      0: return SURR_HIGH_MIN;
      1: return SURR_HIGH_MAX;
      default: return 16'($urandom_range(SURR_HIGH_MIN, SURR_HIGH_MAX));
    endcase
  endfunction

  function automatic logic [15:0] pick_low();
    case ($urandom_range(3))
      0: return SURR_LOW_MIN;
      1: return SURR_LOW_MAX;
      default: return 16'($urandom_range(SURR_LOW_MIN, SURR_LOW_MAX));
    endcase
  endfunction

  // second unit of a pair that is not a low surrogate
  function automatic logic [15:0] pick_bad_low();
    logic [15:0] u;
    case ($urandom_range(3))
      0: u = SURR_HIGH_MAX;
      1: u = 16'he000;
      default: begin
        do u = 16'($urandom); while (u >= SURR_LOW_MIN && u <= SURR_LOW_MAX);
      end
    endcase
    return u;
  endfunction

  function automatic void add_segment();
    case ($urandom_range(5))
      0, 1: add_byte(pick_plain());
      2: begin
        add_byte(CH_BSLASH);
        add_byte(pick_short_escape());
      end
      3, 4: add_unit(pick_bmp());
      default: begin
        add_unit(pick_high());
        add_unit(pick_low());
      end
    endcase
  endfunction

  // start of a unicode escape cut short, on its own or as the low half of a pair
  function automatic void add_unit_head();
    if ($urandom_range(1)) add_unit(pick_high());
    add_byte(CH_BSLASH);
    add_byte(CH_U);
    repeat ($urandom_range(3)) add_byte(hex_char(4'($urandom)));
  endfunction

  // one quoted string with random content, closed normally or broken on purpose
  function automatic void build_string(err_e flaw);
    logic [7:0] c;
    if (flaw == ERR_NO_QUOTE) begin
      if ($urandom_range(1)) add_end();
      else begin
        do c = 8'($urandom); while (c == CH_QUOTE);
        add_byte(c);
      end
      return;
    end
    add_byte(CH_QUOTE);
    repeat ($urandom_range(6)) add_segment();
    case (flaw)
      ERR_NONE:       add_byte(CH_QUOTE);
      ERR_CTRL_CHAR:  add_byte(8'($urandom_range(8'h1f)));
      ERR_INC_ESCAPE: begin
        add_byte(CH_BSLASH);
        add_end();
      end
      ERR_BAD_ESCAPE: begin
        add_byte(CH_BSLASH);
        add_byte(pick_bad_escape());
      end
      ERR_SHORT_UNI: begin
        add_unit_head();
        add_end();
      end
      ERR_BAD_HEX: begin
        add_unit_head();
        add_byte(pick_non_hex());
      end
      ERR_LONE_HIGH: begin
        add_unit(pick_high());
        case ($urandom_range(3))
          0: add_end();
          1: begin
            do c = 8'($urandom); while (c == CH_BSLASH);
            add_byte(c);
          end
          2: begin
            add_byte(CH_BSLASH);
            do c = 8'($urandom); while (c == CH_U);
            add_byte(c);
          end
          default: begin
            add_byte(CH_BSLASH);
            add_end();
          end
        endcase
      end
      ERR_BAD_LOW: begin
        add_unit(pick_high());
        add_unit(pick_bad_low());
      end
      ERR_LONE_LOW: add_unit(pick_low());
      default:      add_end();
    endcase
  endfunction

  // ---- driving requests ----

  // valid is only dropped on an idle cycle, so back to back requests keep it high
  task automatic send_req(in_item_t req);
    while ($urandom_range(99) < src_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    sb.note_request(req);
    reqs_sent++;
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_req(text_q[i]);
    text_q.delete();
  endtask

  initial begin
    int unsigned strings_built;
    err_e        flaw;
    strings_built = 0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: idle rejects, byte extremes, control char, escape faults,
    // bad hex digit, unterminated, empty string, short unicode at end
    add_text("x");
    add_end();
    add_byte(CH_QUOTE);
    add_byte(CH_SPACE);
    add_byte(8'hff);
    add_byte(8'h1f);
    add_text("\"\\q");
    add_text("\"\\");
    add_end();
    add_text("\"\\ug");
    add_byte(CH_QUOTE);
    add_end();
    add_text("\"\"");
    add_text("\"\\u0");
    add_end();
    send_text();

    // random strings: first one of each flaw kind in turn, then half clean and
    // half flawed, with noise now and then; idling swaps at 1/3 and stops at 2/3
    while (reqs_sent < TOTAL_REQS) begin
      if (reqs_sent >= 2 * TOTAL_REQS / 3) begin
        src_idle  = 0;
        sink_idle = 0;
      end else if (reqs_sent >= TOTAL_REQS / 3) begin
        src_idle  = 76;
        sink_idle = 30;
      end
      if (strings_built <= 10) flaw = err_e'(strings_built);
      else if ($urandom_range(1)) flaw = ERR_NONE;
      else flaw = err_e'($urandom_range(1, 10));
      build_string(flaw);
      strings_built++;
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(1)) add_end();
          else add_byte(8'($urandom));
        end
      end
      send_text();
    end
    in_valid_i <= 1'b0;

    // let the result side catch up, then a short quiet spell for stray results
    while (sb.owed_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d requests over %0d strings, %0d results checked",
             sb.requests, strings_built, sb.checked);
    $display("%0d strings decoded to completion, %0d error returns",
             sb.strings_closed, sb.faults);
    if (sb.mismatches == 0 && sb.owed_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/jsu_pkg.sv
rtl/jsu_decode.sv
rtl/json_string_unescaper.sv
rtl/jsu_checker.sv
tb/testbench.sv
